>>> design/quadratic_root_solver_assert.svh
// Assertion macros used by the quadratic root solver top level.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Same-cycle implication, sampled on the clock and masked during reset.
`define QRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the clock and masked during reset.
`define QRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/qrs_pkg.sv
// Shared constants and types of the quadratic root solver.
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ROOT_BITS      = 34;
  localparam int FIFO_DEPTH     = 2;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_TWO  = 2'd2,
    KIND_INF  = 2'd3
  } kind_e;

endpackage

>>> design/qrs_if.sv
// Channel interfaces of the quadratic root solver: coefficients in, roots out.
interface coef_if #(parameter int CW = 16) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] coef_quadratic;
  logic signed [CW-1:0] coef_linear;
  logic signed [CW-1:0] coef_constant;

  modport source (output valid, coef_quadratic, coef_linear, coef_constant, input ready);
  modport sink   (input valid, coef_quadratic, coef_linear, coef_constant, output ready);
endinterface

interface root_if import qrs_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  solution_kind;
  logic signed [ROOT_BITS-1:0] root_first;
  logic signed [ROOT_BITS-1:0] root_second;

  modport source (output valid, solution_kind, root_first, root_second, input ready);
  modport sink   (input valid, solution_kind, root_first, root_second, output ready);
endinterface

>>> design/qrs_front.sv
// Front end: takes coefficient triples, forms the discriminant and classifies the job.
module qrs_front import qrs_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  coef_if.sink                                   coef_i,
  output logic                                   job_valid_o,
  input  logic                                   job_ready_i,
  output kind_e                                  job_kind_o,
  output logic [2*COEF_WIDTH+1:0]                job_dmag_o,
  output logic signed [COEF_WIDTH+FRAC_BITS:0]   job_base_o,
  output logic signed [COEF_WIDTH:0]             job_den_o
);

  localparam int CW = COEF_WIDTH;
  localparam int DW = 2 * CW + 2;
  localparam int BW = CW + FRAC_BITS + 1;

  logic                 en;
  logic                 s1_v_q, s2_v_q, s3_v_q;
  logic signed [CW-1:0] s1_a_q, s1_b_q, s1_c_q;
  logic signed [CW-1:0] s2_a_q, s2_b_q, s2_c_q;
  logic [2*CW-1:0]      s2_bb_q, s2_ac_q;
  logic [CW-1:0]        a_mag, b_mag, c_mag;
  kind_e                kind_d, kind_q;
  logic [DW-1:0]        dmag_d, dmag_q;
  logic signed [BW-1:0] base_d, base_q;
  logic signed [CW:0]   den_d, den_q;

  // The whole front advances together unless the last stage is held.
  assign en           = !s3_v_q || job_ready_i;
  assign coef_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= coef_i.valid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // Magnitudes of the coefficients for the unsigned products.
  assign a_mag = s1_a_q[CW-1] ? CW'(-s1_a_q) : CW'(s1_a_q);
  assign b_mag = s1_b_q[CW-1] ? CW'(-s1_b_q) : CW'(s1_b_q);
  assign c_mag = s1_c_q[CW-1] ? CW'(-s1_c_q) : CW'(s1_c_q);

  // Classification of the equation and operands for the back end.
  always_comb begin
    logic [DW-1:0]        bb_x;
    logic [DW-1:0]        ac4_x;
    logic                 a_zero, b_zero, c_zero, ac_neg;
    logic signed [BW-1:0] b_x, c_x;
    bb_x   = DW'(s2_bb_q);
    ac4_x  = {s2_ac_q, 2'b00};
    a_zero = (s2_a_q == '0);
    b_zero = (s2_b_q == '0);
    c_zero = (s2_c_q == '0);
    ac_neg = (s2_a_q[CW-1] != s2_c_q[CW-1]) && !c_zero;
    b_x    = BW'(s2_b_q);
    c_x    = BW'(s2_c_q);
    dmag_d = '0;
    if (a_zero) begin
      den_d  = (CW+1)'(s2_b_q);
      base_d = -(c_x <<< FRAC_BITS);
      if (!b_zero) begin
        kind_d = KIND_ONE;
      end else if (c_zero) begin
        kind_d = KIND_INF;
      end else begin
        kind_d = KIND_NONE;
      end
    end else begin
      den_d  = {s2_a_q, 1'b0};
      base_d = -(b_x <<< FRAC_BITS);
      if (ac_neg) begin
        dmag_d = bb_x + ac4_x;
        kind_d = KIND_TWO;
      end else if (bb_x >= ac4_x) begin
        dmag_d = bb_x - ac4_x;
        kind_d = (dmag_d == '0) ? KIND_ONE : KIND_TWO;
      end else begin
        kind_d = KIND_NONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a_q  <= coef_i.coef_quadratic;
      s1_b_q  <= coef_i.coef_linear;
      s1_c_q  <= coef_i.coef_constant;
      s2_a_q  <= s1_a_q;
      s2_b_q  <= s1_b_q;
      s2_c_q  <= s1_c_q;
      s2_bb_q <= b_mag * b_mag;
      s2_ac_q <= a_mag * c_mag;
      kind_q  <= kind_d;
      dmag_q  <= dmag_d;
      base_q  <= base_d;
      den_q   <= den_d;
    end
  end

  assign job_valid_o = s3_v_q;
  assign job_kind_o  = kind_q;
  assign job_dmag_o  = dmag_q;
  assign job_base_o  = base_q;
  assign job_den_o   = den_q;

endmodule

>>> design/qrs_fifo.sv
// Short job queue between the front end and the back end.
module qrs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNTW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointers wrap at the queue depth; the count tracks occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> design/qrs_back.sv
// Back end: pipelined square root, two pipelined dividers and root saturation.
module qrs_back import qrs_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 job_valid_i,
  output logic                                 job_ready_o,
  input  kind_e                                job_kind_i,
  input  logic [2*COEF_WIDTH+1:0]              job_dmag_i,
  input  logic signed [COEF_WIDTH+FRAC_BITS:0] job_base_i,
  input  logic signed [COEF_WIDTH:0]           job_den_i,
  root_if.source                               root_o
);

  localparam int CW  = COEF_WIDTH;
  localparam int SW  = CW + FRAC_BITS + 1;   // square root bits
  localparam int RW  = SW + 2;               // square root remainder
  localparam int MW  = SW + 1;               // numerator and quotient magnitude
  localparam int BW  = CW + FRAC_BITS + 1;
  localparam int VW  = CW + 1;               // divisor magnitude
  localparam int QRW = CW + 2;               // divider remainder
  localparam int XW  = (MW + 1 > ROOT_BITS) ? MW + 1 : ROOT_BITS;
  localparam logic signed [XW-1:0] ROOT_MAX = XW'({1'b0, {(ROOT_BITS-1){1'b1}}});
  localparam logic signed [XW-1:0] ROOT_MIN = -ROOT_MAX - 1;

  logic en;

  // Square root pipeline, one result bit per stage.
  logic                 sq_v_q    [SW+1];
  logic [2*SW-1:0]      sq_rad_q  [SW+1];
  logic [RW-1:0]        sq_rem_q  [SW+1];
  logic [SW-1:0]        sq_root_q [SW+1];
  kind_e                sq_kind_q [SW+1];
  logic signed [BW-1:0] sq_base_q [SW+1];
  logic signed [CW:0]   sq_den_q  [SW+1];

  // Divider pipeline, two lanes sharing one divisor, one quotient bit per stage.
  logic             dv_v_q    [MW+1];
  kind_e            dv_kind_q [MW+1];
  logic [VW-1:0]    dv_den_q  [MW+1];
  logic [MW-1:0]    dv_na_q   [MW+1];
  logic [MW-1:0]    dv_nb_q   [MW+1];
  logic [QRW-1:0]   dv_ra_q   [MW+1];
  logic [QRW-1:0]   dv_rb_q   [MW+1];
  logic [MW-1:0]    dv_qa_q   [MW+1];
  logic [MW-1:0]    dv_qb_q   [MW+1];
  logic             dv_sa_q   [MW+1];
  logic             dv_sb_q   [MW+1];

  logic                        out_v_q;
  logic [1:0]                  out_kind_q;
  logic signed [ROOT_BITS-1:0] out_r1_q, out_r2_q;

  // The pipeline moves as one unless the output register is held.
  assign en          = !out_v_q || root_o.ready;
  assign job_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (en) begin
      sq_v_q[0] <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rad_q[0]  <= {job_dmag_i, {(2*FRAC_BITS){1'b0}}};
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_kind_q[0] <= job_kind_i;
      sq_base_q[0] <= job_base_i;
      sq_den_q[0]  <= job_den_i;
    end
  end

  for (genvar i = 1; i <= SW; i++) begin : g_sqrt
    logic [RW+1:0] cur, trl, dif;
    logic          take;

    // Bring down the next two radicand bits and try the next root bit.
    assign cur  = {sq_rem_q[i-1], sq_rad_q[i-1][2*SW-1 -: 2]};
    assign trl  = (RW+2)'({sq_root_q[i-1], 2'b01});
    assign dif  = cur - trl;
    assign take = (cur >= trl);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[i] <= 1'b0;
      end else if (en) begin
        sq_v_q[i] <= sq_v_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rad_q[i]  <= sq_rad_q[i-1] << 2;
        sq_rem_q[i]  <= take ? dif[RW-1:0] : cur[RW-1:0];
        sq_root_q[i] <= {sq_root_q[i-1][SW-2:0], take};
        sq_kind_q[i] <= sq_kind_q[i-1];
        sq_base_q[i] <= sq_base_q[i-1];
        sq_den_q[i]  <= sq_den_q[i-1];
      end
    end
  end

  // Form both numerators from the root and split them into sign and magnitude.
  logic signed [MW:0] base_x, s_x, num_a, num_b;
  logic               den_neg;

  assign base_x  = (MW+1)'(sq_base_q[SW]);
  assign s_x     = signed'((MW+1)'(sq_root_q[SW]));
  assign num_a   = base_x + s_x;
  assign num_b   = base_x - s_x;
  assign den_neg = sq_den_q[SW][CW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= sq_v_q[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_kind_q[0] <= sq_kind_q[SW];
      dv_den_q[0]  <= den_neg ? VW'(-sq_den_q[SW]) : VW'(sq_den_q[SW]);
      dv_na_q[0]   <= num_a[MW] ? MW'(-num_a) : MW'(num_a);
      dv_nb_q[0]   <= num_b[MW] ? MW'(-num_b) : MW'(num_b);
      dv_ra_q[0]   <= '0;
      dv_rb_q[0]   <= '0;
      dv_qa_q[0]   <= '0;
      dv_qb_q[0]   <= '0;
      dv_sa_q[0]   <= num_a[MW] ^ den_neg;
      dv_sb_q[0]   <= num_b[MW] ^ den_neg;
    end
  end

  for (genvar i = 1; i <= MW; i++) begin : g_div
    logic [QRW:0] den_x, cur_a, cur_b, dif_a, dif_b;
    logic         take_a, take_b;

    // Restoring division step on both lanes.
    assign den_x  = (QRW+1)'(dv_den_q[i-1]);
    assign cur_a  = {dv_ra_q[i-1], dv_na_q[i-1][MW-1]};
    assign cur_b  = {dv_rb_q[i-1], dv_nb_q[i-1][MW-1]};
    assign dif_a  = cur_a - den_x;
    assign dif_b  = cur_b - den_x;
    assign take_a = (cur_a >= den_x);
    assign take_b = (cur_b >= den_x);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[i] <= 1'b0;
      end else if (en) begin
        dv_v_q[i] <= dv_v_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_kind_q[i] <= dv_kind_q[i-1];
        dv_den_q[i]  <= dv_den_q[i-1];
        dv_na_q[i]   <= dv_na_q[i-1] << 1;
        dv_nb_q[i]   <= dv_nb_q[i-1] << 1;
        dv_ra_q[i]   <= take_a ? dif_a[QRW-1:0] : cur_a[QRW-1:0];
        dv_rb_q[i]   <= take_b ? dif_b[QRW-1:0] : cur_b[QRW-1:0];
        dv_qa_q[i]   <= {dv_qa_q[i-1][MW-2:0], take_a};
        dv_qb_q[i]   <= {dv_qb_q[i-1][MW-2:0], take_b};
        dv_sa_q[i]   <= dv_sa_q[i-1];
        dv_sb_q[i]   <= dv_sb_q[i-1];
      end
    end
  end

  // Apply the quotient signs, saturate to the root width and blank unused roots.
  logic signed [XW-1:0]        val_a, val_b;
  logic signed [ROOT_BITS-1:0] sat_a, sat_b, r1_d, r2_d;
  kind_e                       fin_kind;

  assign fin_kind = dv_kind_q[MW];
  assign val_a = dv_sa_q[MW] ? -XW'(signed'({1'b0, dv_qa_q[MW]}))
                             :  XW'(signed'({1'b0, dv_qa_q[MW]}));
  assign val_b = dv_sb_q[MW] ? -XW'(signed'({1'b0, dv_qb_q[MW]}))
                             :  XW'(signed'({1'b0, dv_qb_q[MW]}));

  always_comb begin
    if (val_a > ROOT_MAX) begin
      sat_a = ROOT_MAX[ROOT_BITS-1:0];
    end else if (val_a < ROOT_MIN) begin
      sat_a = ROOT_MIN[ROOT_BITS-1:0];
    end else begin
      sat_a = val_a[ROOT_BITS-1:0];
    end
    if (val_b > ROOT_MAX) begin
      sat_b = ROOT_MAX[ROOT_BITS-1:0];
    end else if (val_b < ROOT_MIN) begin
      sat_b = ROOT_MIN[ROOT_BITS-1:0];
    end else begin
      sat_b = val_b[ROOT_BITS-1:0];
    end
    case (fin_kind)
      KIND_ONE: begin
        r1_d = sat_a;
        r2_d = '0;
      end
      KIND_TWO: begin
        r1_d = sat_a;
        r2_d = sat_b;
      end
      default: begin
        r1_d = '0;
        r2_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v_q[MW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_kind_q <= fin_kind;
      out_r1_q   <= r1_d;
      out_r2_q   <= r2_d;
    end
  end

  assign root_o.valid         = out_v_q;
  assign root_o.solution_kind = out_kind_q;
  assign root_o.root_first    = out_r1_q;
  assign root_o.root_second   = out_r2_q;

endmodule

>>> design/quadratic_root_solver.sv
// Quadratic root solver top level: front end, job queue and back end.
//
// Usage: coefficient triples a, b, c arrive on coef_i as valid/ready
// transfers; each triple yields exactly one transfer on root_o with the
// solution kind and two signed roots with FRAC_BITS fraction bits.
// Throughput: one triple per cycle, sustained, as long as root_o is ready.
// The path from input transfer to output valid runs through the three
// front stages, the job queue, one square root stage per root bit and
// one divider stage per quotient bit.
// Reset clears all valid flags and the queue; no output is valid afterward
// until a triple has passed through.
// When the receiver stalls, the back end holds, the queue fills, then the
// front end holds and coef_i.ready falls; no transfer is lost or repeated.
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  coef_if.sink   coef_i,
  root_if.source root_o
);

`include "quadratic_root_solver_assert.svh"

  localparam int DW = 2 * COEF_WIDTH + 2;
  localparam int BW = COEF_WIDTH + FRAC_BITS + 1;
  localparam int VW = COEF_WIDTH + 1;
  localparam int JW = 2 + DW + BW + VW;

  logic                 fr_valid, fr_ready, bk_valid, bk_ready;
  kind_e                fr_kind, bk_kind;
  logic [DW-1:0]        fr_dmag, bk_dmag;
  logic signed [BW-1:0] fr_base, bk_base;
  logic signed [VW-1:0] fr_den, bk_den;
  logic [JW-1:0]        push_data, pop_data;

  qrs_front #(
    .COEF_WIDTH (COEF_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_i),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready),
    .job_kind_o  (fr_kind),
    .job_dmag_o  (fr_dmag),
    .job_base_o  (fr_base),
    .job_den_o   (fr_den)
  );

  // Jobs cross the queue as one packed word.
  assign push_data = {fr_kind, fr_dmag, fr_base, fr_den};

  qrs_fifo #(
    .WIDTH (JW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (pop_data)
  );

  assign bk_kind = kind_e'(pop_data[JW-1 -: 2]);
  assign bk_dmag = pop_data[VW+BW +: DW];
  assign bk_base = signed'(pop_data[VW +: BW]);
  assign bk_den  = signed'(pop_data[VW-1:0]);

  qrs_back #(
    .COEF_WIDTH (COEF_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bk_valid),
    .job_ready_o (bk_ready),
    .job_kind_i  (bk_kind),
    .job_dmag_i  (bk_dmag),
    .job_base_i  (bk_base),
    .job_den_i   (bk_den),
    .root_o      (root_o)
  );

  // Roots that the solution kind does not use must read zero.
  `QRS_ASSERT_NOW(a_unused_roots_zero,
    root_o.valid && (root_o.solution_kind == KIND_NONE || root_o.solution_kind == KIND_INF),
    root_o.root_first == '0 && root_o.root_second == '0,
    "root reported for a kind without roots")

  `QRS_ASSERT_NOW(a_single_root_second_zero,
    root_o.valid && root_o.solution_kind == KIND_ONE,
    root_o.root_second == '0,
    "second root nonzero for a single root")

  // An empty queue that gets no job stays empty.
  `QRS_ASSERT_NXT(a_queue_empty_holds,
    !bk_valid && !(fr_valid && fr_ready),
    !bk_valid,
    "job appeared in the queue without a push")

endmodule

>>> bench/quadratic_root_solver_tb.sv
// Self-checking testbench of the quadratic root solver: directed table, then random triples.
`timescale 1ns / 1ps

module quadratic_root_solver_tb;
  import qrs_pkg::*;

  localparam int CW        = COEF_WIDTH_DEF;
  localparam int FB        = FRAC_BITS_DEF;
  localparam int N_RANDOM  = 900;
  localparam int IDLE_MAX  = 3000;
  localparam int DRAIN_CYC = 120;
  localparam longint ONE_FX = longint'(1) << FB;

  typedef struct {
    logic signed [CW-1:0]        a;
    logic signed [CW-1:0]        b;
    logic signed [CW-1:0]        c;
    bit                          typed;
    kind_e                       kind;
    logic signed [ROOT_BITS-1:0] r1;
    logic signed [ROOT_BITS-1:0] r2;
  } triple_t;

  typedef struct {
    kind_e                       kind;
    logic signed [ROOT_BITS-1:0] r1;
    logic signed [ROOT_BITS-1:0] r2;
  } roots_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  coef_if #(.CW(CW)) coef_bus ();
  root_if            root_bus ();

  quadratic_root_solver u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef_bus),
    .root_o (root_bus)
  );

  always #6 clk_i = ~clk_i;

  triple_t stim_q[$];
  roots_t  pending_roots[$];
  int      n_fail = 0;

  // Integer square root of d * 4^FB, two bits per step.
  function automatic longint unsigned isqrt_scaled(longint unsigned d);
    bit [127:0] v;
    bit [127:0] rem;
    bit [127:0] root;
    bit [127:0] trial;
    v = 128'(d) << (2 * FB);
    rem = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return longint'(root[63:0]);
  endfunction

  // Clamp a root to the signed output width.
  function automatic logic signed [ROOT_BITS-1:0] clamp_root(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (ROOT_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[ROOT_BITS-1:0];
  endfunction

  // Solution kind and roots of a*x^2 + b*x + c = 0 in fixed point.
  function automatic roots_t solve_roots(logic signed [CW-1:0] ai, logic signed [CW-1:0] bi,
                                         logic signed [CW-1:0] ci);
    roots_t  res;
    longint  a;
    longint  b;
    longint  c;
    longint  disc;
    longint  s;
    longint  nb;
    longint  r1;
    longint  r2;
    a = ai;
    b = bi;
    c = ci;
    r1 = 0;
    r2 = 0;
    if (a == 0) begin
      if (b == 0) begin
        res.kind = (c == 0) ? KIND_INF : KIND_NONE;
      end else begin
        res.kind = KIND_ONE;
        r1 = (-(c * ONE_FX)) / b;
      end
    end else begin
      disc = b * b - 4 * a * c;
      nb = -(b * ONE_FX);
      if (disc == 0) begin
        res.kind = KIND_ONE;
        r1 = nb / (2 * a);
      end else if (disc > 0) begin
        s = longint'(isqrt_scaled(longint'(disc)));
        res.kind = KIND_TWO;
        r1 = (nb + s) / (2 * a);
        r2 = (nb - s) / (2 * a);
      end else begin
        res.kind = KIND_NONE;
      end
    end
    res.r1 = clamp_root(r1);
    res.r2 = clamp_root(r2);
    return res;
  endfunction

  function automatic triple_t row(int a, int b, int c, bit typed = 0,
                                  kind_e k = KIND_NONE, longint r1 = 0, longint r2 = 0);
    triple_t t;
    t.a = a[CW-1:0];
    t.b = b[CW-1:0];
    t.c = c[CW-1:0];
    t.typed = typed;
    t.kind = k;
    t.r1 = r1[ROOT_BITS-1:0];
    t.r2 = r2[ROOT_BITS-1:0];
    return t;
  endfunction

  function automatic int small_coef(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // Random triple: a mix of random, root-built, linear, small and extreme triples.
  function automatic triple_t random_triple();
    int sel;
    int a;
    int p;
    int q;
    sel = $urandom_range(99);
    if (sel < 30) begin
      return row($urandom, $urandom, $urandom);
    end else if (sel < 55) begin
      a = small_coef(60);
      p = small_coef(40);
      q = ($urandom_range(3) == 0) ? p : small_coef(40);
      return row(a, -a * (p + q), a * p * q);
    end else if (sel < 70) begin
      return row(0, ($urandom_range(4) == 0) ? 0 : $urandom, $urandom_range(3) == 0 ? 0 : $urandom);
    end else if (sel < 85) begin
      return row(small_coef(8), small_coef(8), small_coef(8));
    end else begin
      a = ($urandom_range(1) == 0) ? -32768 : 32767;
      return row($urandom_range(1) ? a : small_coef(3), $urandom_range(1) ? -a - 1 : $urandom,
                 $urandom_range(1) ? a : small_coef(3));
    end
  endfunction

  initial begin
    int      n_dir;
    int      next_idx;
    int      burst_left;
    int      gap_left;
    int      idle_cycles;
    int      drain_left;
    int      n_out;
    bit      next_valid;
    bit      stim_done;
    bit [15:0] stall_mask;
    triple_t cur;
    roots_t  exp_r;

    coef_bus.valid          = 1'b0;
    coef_bus.coef_quadratic = '0;
    coef_bus.coef_linear    = '0;
    coef_bus.coef_constant  = '0;
    root_bus.ready          = 1'b0;

    // Directed rows; typed expectations where they are obvious.
    stim_q.push_back(row(0, 0, 0, 1, KIND_INF));
    stim_q.push_back(row(0, 0, 5, 1, KIND_NONE));
    stim_q.push_back(row(0, 0, -32768, 1, KIND_NONE));
    stim_q.push_back(row(0, 2, -4, 1, KIND_ONE, 131072));
    stim_q.push_back(row(0, 1, -32768, 1, KIND_ONE, 64'sd2147483648));
    stim_q.push_back(row(0, -32768, 32767));
    stim_q.push_back(row(0, 32767, -32768));
    stim_q.push_back(row(1, 0, 1, 1, KIND_NONE));
    stim_q.push_back(row(32767, 32767, 32767, 1, KIND_NONE));
    stim_q.push_back(row(1, 2, 1, 1, KIND_ONE, -65536));
    stim_q.push_back(row(1, 0, -1, 1, KIND_TWO, 65536, -65536));
    stim_q.push_back(row(-1, 0, 1, 1, KIND_TWO, -65536, 65536));
    stim_q.push_back(row(1, 0, 0, 1, KIND_ONE, 0));
    stim_q.push_back(row(-32768, -32768, -32768));
    stim_q.push_back(row(-32768, -32768, 32767));
    stim_q.push_back(row(1, -32768, -32768));
    stim_q.push_back(row(1, 32767, 0));
    stim_q.push_back(row(-32768, 0, 32767));
    stim_q.push_back(row(32767, -32768, 0));
    stim_q.push_back(row(3, 5, -7));
    stim_q.push_back(row(-1, -1, -1));
    n_dir = stim_q.size();
    for (int i = 0; i < N_RANDOM; i++) stim_q.push_back(random_triple());

    next_idx = 0;
    burst_left = 1 + $urandom_range(12);
    gap_left = 0;
    idle_cycles = 0;
    drain_left = DRAIN_CYC;
    n_out = 0;
    stim_done = 0;
    stall_mask = 16'hffff;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    forever begin
      @(posedge clk_i);
      idle_cycles++;

      // Input transfer: queue the expected roots.
      if (coef_bus.valid && coef_bus.ready) begin
        cur = stim_q[next_idx];
        if (cur.typed) begin
          exp_r.kind = cur.kind;
          exp_r.r1 = cur.r1;
          exp_r.r2 = cur.r2;
        end else begin
          exp_r = solve_roots(cur.a, cur.b, cur.c);
        end
        pending_roots.push_back(exp_r);
        next_idx++;
        idle_cycles = 0;
      end

      // Output transfer: compare with the oldest expectation.
      if (root_bus.valid && root_bus.ready) begin
        idle_cycles = 0;
        n_out++;
        if (pending_roots.size() == 0) begin
          $error("unexpected result transfer: kind %0d", root_bus.solution_kind);
          n_fail++;
        end else begin
          exp_r = pending_roots.pop_front();
          if (root_bus.solution_kind !== exp_r.kind) begin
            $error("solution_kind: expected %0d, got %0d", exp_r.kind, root_bus.solution_kind);
            n_fail++;
          end
          if (root_bus.root_first !== exp_r.r1) begin
            $error("root_first: expected %0d, got %0d", exp_r.r1, root_bus.root_first);
            n_fail++;
          end
          if (root_bus.root_second !== exp_r.r2) begin
            $error("root_second: expected %0d, got %0d", exp_r.r2, root_bus.root_second);
            n_fail++;
          end
        end
      end

      // Sender: hold an offered triple, else run bursts with gaps.
      if (coef_bus.valid && !coef_bus.ready) begin
        next_valid = 1'b1;
      end else if (next_idx >= stim_q.size()) begin
        next_valid = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        next_valid = 1'b0;
      end else begin
        next_valid = 1'b1;
        cur = stim_q[next_idx];
        coef_bus.coef_quadratic <= cur.a;
        coef_bus.coef_linear    <= cur.b;
        coef_bus.coef_constant  <= cur.c;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = 1 + $urandom_range(20);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
        end
      end
      coef_bus.valid <= next_valid;

      // Receiver: stall pattern rotates, renewed now and then.
      if ($urandom_range(150) == 0) begin
        case ($urandom_range(3))
          0: stall_mask = 16'hffff;
          1: stall_mask = 16'h0001;
          default: stall_mask = $urandom | 16'h0001;
        endcase
      end
      stall_mask = {stall_mask[14:0], stall_mask[15]};
      root_bus.ready <= stall_mask[0];

      // End of run: drain, settle, then report.
      stim_done = (next_idx >= stim_q.size());
      if (stim_done && pending_roots.size() == 0) begin
        drain_left--;
        if (drain_left == 0) begin
          $display("Covered %0d directed and %0d random triples, %0d results checked.",
                   n_dir, N_RANDOM, n_out);
          if (n_fail == 0) begin
            $display("quadratic_root_solver verification clean");
          end else begin
            $display("quadratic_root_solver verification failed");
          end
          $finish;
        end
      end else if (idle_cycles >= IDLE_MAX) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding.",
                 idle_cycles, pending_roots.size());
        $display("quadratic_root_solver verification failed");
        $finish;
      end
    end
  end

endmodule

>>> files.f
+incdir+design
design/qrs_pkg.sv
design/qrs_if.sv
design/qrs_front.sv
design/qrs_fifo.sv
design/qrs_back.sv
design/quadratic_root_solver.sv
bench/quadratic_root_solver_tb.sv
